// ===== rtl/rmq_pkg.sv =====
package rmq_pkg;

    localparam int FRAC_BITS = 14;
    localparam int DW        = 16;
    localparam int ONE       = 1 << FRAC_BITS;

    // radicand is at most ONE plus three full-scale entries
    localparam int RAD_W  = $clog2(ONE + 3 * (1 << (DW - 1)) + 1);
    localparam int RS_W   = RAD_W + 2;
    localparam int TW     = DW + 2;
    localparam int SQ_W   = RAD_W + FRAC_BITS;
    localparam int ROOT_W = (SQ_W + 1) / 2;
    localparam int N_W    = DW + 1;
    localparam int NUM_W  = ((N_W + FRAC_BITS > ROOT_W) ? N_W + FRAC_BITS : ROOT_W) + 1;
    localparam int DEN_W  = ROOT_W + 1;
    localparam int QUO_W  = DW;
    localparam int DIV_LAT = QUO_W + 2;

    localparam logic signed [DW-1:0] QMAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] QMIN = {1'b1, {(DW-1){1'b0}}};

    typedef enum logic [1:0] {
        SEL_W = 2'd0,
        SEL_X = 2'd1,
        SEL_Y = 2'd2,
        SEL_Z = 2'd3
    } sel_t;

    typedef struct packed {
        sel_t                  sel;
        logic signed [N_W-1:0] n0;
        logic signed [N_W-1:0] n1;
        logic signed [N_W-1:0] n2;
    } side_t;

endpackage

// ===== rtl/rmq_prep.sv =====
module rmq_prep (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          ce,
    input  logic                          in_vld,
    input  logic signed [rmq_pkg::DW-1:0] m00,
    input  logic signed [rmq_pkg::DW-1:0] m01,
    input  logic signed [rmq_pkg::DW-1:0] m02,
    input  logic signed [rmq_pkg::DW-1:0] m10,
    input  logic signed [rmq_pkg::DW-1:0] m11,
    input  logic signed [rmq_pkg::DW-1:0] m12,
    input  logic signed [rmq_pkg::DW-1:0] m20,
    input  logic signed [rmq_pkg::DW-1:0] m21,
    input  logic signed [rmq_pkg::DW-1:0] m22,
    output logic                          out_vld,
    output logic [rmq_pkg::RAD_W-1:0]     out_rad,
    output rmq_pkg::side_t                out_side
);
    import rmq_pkg::*;

    logic signed [TW-1:0]   trace;
    logic signed [RS_W-1:0] rad_s;
    logic signed [N_W-1:0]  e01, e02, e10, e12, e20, e21;
    sel_t                   sel;
    side_t                  side_next;
    logic [RAD_W-1:0]       rad_next;
    logic                   vld_reg;
    logic [RAD_W-1:0]       rad_reg;
    side_t                  side_reg;

    assign trace = TW'(m00) + TW'(m11) + TW'(m22);
    assign e01 = N_W'(m01);
    assign e02 = N_W'(m02);
    assign e10 = N_W'(m10);
    assign e12 = N_W'(m12);
    assign e20 = N_W'(m20);
    assign e21 = N_W'(m21);

    always_comb begin
        priority if (trace > 0) begin
            sel = SEL_W;
        end else if (m00 > m11 && m00 > m22) begin
            sel = SEL_X;
        end else if (m11 > m22) begin
            sel = SEL_Y;
        end else begin
            sel = SEL_Z;
        end
    end

    always_comb begin
        side_next.sel = sel;
        unique case (sel)
            SEL_W: begin
                rad_s = RS_W'(ONE) + RS_W'(trace);
                side_next.n0 = e21 - e12;
                side_next.n1 = e02 - e20;
                side_next.n2 = e10 - e01;
            end
            SEL_X: begin
                rad_s = RS_W'(ONE) + RS_W'(m00) - RS_W'(m11) - RS_W'(m22);
                side_next.n0 = e01 + e10;
                side_next.n1 = e02 + e20;
                side_next.n2 = e21 - e12;
            end
            SEL_Y: begin
                rad_s = RS_W'(ONE) + RS_W'(m11) - RS_W'(m00) - RS_W'(m22);
                side_next.n0 = e01 + e10;
                side_next.n1 = e12 + e21;
                side_next.n2 = e02 - e20;
            end
            default: begin
                rad_s = RS_W'(ONE) + RS_W'(m22) - RS_W'(m00) - RS_W'(m11);
                side_next.n0 = e02 + e20;
                side_next.n1 = e12 + e21;
                side_next.n2 = e10 - e01;
            end
        endcase
    end

    // negative radicand gives a zero root
    assign rad_next = rad_s[RS_W-1] ? '0 : RAD_W'(rad_s);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (ce) begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            rad_reg  <= rad_next;
            side_reg <= side_next;
        end
    end

    assign out_vld  = vld_reg;
    assign out_rad  = rad_reg;
    assign out_side = side_reg;

endmodule

// ===== rtl/rmq_sqrt.sv =====
module rmq_sqrt (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       ce,
    input  logic                       in_vld,
    input  logic [rmq_pkg::RAD_W-1:0]  in_rad,
    input  rmq_pkg::side_t             in_side,
    output logic                       out_vld,
    output logic [rmq_pkg::ROOT_W-1:0] out_root,
    output rmq_pkg::side_t             out_side
);
    import rmq_pkg::*;

    localparam int CW = 2 * ROOT_W + 1;

    logic [ROOT_W-1:0] vld_reg;
    logic [SQ_W-1:0]   rem_reg  [ROOT_W];
    logic [ROOT_W-1:0] root_reg [ROOT_W];
    side_t             side_reg [ROOT_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (ce) begin
            vld_reg <= {vld_reg[ROOT_W-2:0], in_vld};
        end
    end

    // one root bit per stage, MSB first
    for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
        localparam int B = ROOT_W - 1 - k;
        logic [SQ_W-1:0]   rem_prev;
        logic [ROOT_W-1:0] root_prev;
        side_t             side_prev;
        logic [CW-1:0]     cand;
        logic [CW-1:0]     rem_ext;
        logic              ge;
        logic [SQ_W-1:0]   rem_next;
        logic [ROOT_W-1:0] root_next;

        if (k == 0) begin : g_first
            assign rem_prev  = SQ_W'(in_rad) << FRAC_BITS;
            assign root_prev = '0;
            assign side_prev = in_side;
        end else begin : g_rest
            assign rem_prev  = rem_reg[k-1];
            assign root_prev = root_reg[k-1];
            assign side_prev = side_reg[k-1];
        end

        assign cand      = (CW'(root_prev) << (B + 1)) + (CW'(1) << (2 * B));
        assign rem_ext   = CW'(rem_prev);
        assign ge        = rem_ext >= cand;
        assign rem_next  = ge ? SQ_W'(rem_ext - cand) : rem_prev;
        assign root_next = ge ? (root_prev | (ROOT_W'(1) << B)) : root_prev;

        always_ff @(posedge aclk) begin
            if (ce) begin
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
                side_reg[k] <= side_prev;
            end
        end
    end

    assign out_vld  = vld_reg[ROOT_W-1];
    assign out_root = root_reg[ROOT_W-1];
    assign out_side = side_reg[ROOT_W-1];

endmodule

// ===== rtl/rmq_div.sv =====
module rmq_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          ce,
    input  logic                          in_vld,
    input  logic signed [rmq_pkg::N_W-1:0] in_n,
    input  logic [rmq_pkg::ROOT_W-1:0]    in_root,
    output logic                          out_vld,
    output logic signed [rmq_pkg::DW-1:0] out_q
);
    import rmq_pkg::*;

    localparam int EW = ((NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W) + 1;

    logic [DIV_LAT-1:0] vld_reg;

    // setup stage
    logic [N_W-1:0]   mag;
    logic [NUM_W-1:0] num_next;
    logic [NUM_W-1:0] num_reg;
    logic [DEN_W-1:0] den_reg;
    logic             neg_reg;
    logic             zero_reg;

    // quotient stages
    logic [NUM_W-1:0] rem_reg  [QUO_W];
    logic [QUO_W-1:0] q_reg    [QUO_W];
    logic [DEN_W-1:0] dq_reg   [QUO_W];
    logic             ovf_reg  [QUO_W];
    logic             negq_reg [QUO_W];
    logic             zq_reg   [QUO_W];

    logic signed [DW-1:0] res_next;
    logic signed [DW-1:0] res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (ce) begin
            vld_reg <= {vld_reg[DIV_LAT-2:0], in_vld};
        end
    end

    // n * ONE / (2r), rounded: ((|n| << F) + r) / (2r)
    assign mag      = in_n[N_W-1] ? N_W'(-in_n) : N_W'(in_n);
    assign num_next = (NUM_W'(mag) << FRAC_BITS) + NUM_W'(in_root);

    always_ff @(posedge aclk) begin
        if (ce) begin
            num_reg  <= num_next;
            den_reg  <= {in_root, 1'b0};
            neg_reg  <= in_n[N_W-1];
            zero_reg <= (mag == '0);
        end
    end

    for (genvar k = 0; k < QUO_W; k++) begin : g_stage
        localparam int B = QUO_W - 1 - k;
        logic [NUM_W-1:0] rem_prev;
        logic [QUO_W-1:0] q_prev;
        logic [DEN_W-1:0] d_prev;
        logic             ovf_prev;
        logic             neg_prev;
        logic             z_prev;
        logic [EW-1:0]    dsh;
        logic [EW-1:0]    rem_ext;
        logic             ge;

        if (k == 0) begin : g_first
            assign rem_prev = num_reg;
            assign q_prev   = '0;
            assign d_prev   = den_reg;
            // quotient does not fit in QUO_W bits
            assign ovf_prev = EW'(num_reg) >= (EW'(den_reg) << QUO_W);
            assign neg_prev = neg_reg;
            assign z_prev   = zero_reg;
        end else begin : g_rest
            assign rem_prev = rem_reg[k-1];
            assign q_prev   = q_reg[k-1];
            assign d_prev   = dq_reg[k-1];
            assign ovf_prev = ovf_reg[k-1];
            assign neg_prev = negq_reg[k-1];
            assign z_prev   = zq_reg[k-1];
        end

        assign dsh     = EW'(d_prev) << B;
        assign rem_ext = EW'(rem_prev);
        assign ge      = rem_ext >= dsh;

        always_ff @(posedge aclk) begin
            if (ce) begin
                rem_reg[k]  <= ge ? NUM_W'(rem_ext - dsh) : rem_prev;
                q_reg[k]    <= ge ? (q_prev | (QUO_W'(1) << B)) : q_prev;
                dq_reg[k]   <= d_prev;
                ovf_reg[k]  <= ovf_prev;
                negq_reg[k] <= neg_prev;
                zq_reg[k]   <= z_prev;
            end
        end
    end

    // sign and saturation
    always_comb begin
        logic [QUO_W-1:0] q;
        q = q_reg[QUO_W-1];
        priority if (zq_reg[QUO_W-1]) begin
            res_next = '0;
        end else if (!negq_reg[QUO_W-1]) begin
            res_next = (ovf_reg[QUO_W-1] || q > QUO_W'(QMAX)) ? QMAX : DW'(q);
        end else begin
            res_next = (ovf_reg[QUO_W-1] || q > (QUO_W'(1) << (DW - 1)))
                       ? QMIN : DW'(~q + QUO_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            res_reg <= res_next;
        end
    end

    assign out_vld = vld_reg[DIV_LAT-1];
    assign out_q   = res_reg;

endmodule

// ===== rtl/rotation_matrix_to_quaternion_top.sv =====
// Channel   Ports                                  Direction  Content
// s_        s_valid s_ready s_m00 .. s_m22         in         one 3x3 matrix, Q1.14
// m_        m_valid m_ready m_quat_x/y/z/w         out        unit quaternion, Q1.14
//           m_case_used                                       0 trace, 1/2/3 diagonal
//
// One item per cycle while the output is not blocked; stages in order: case select,
// root, divide, output register.
// The root and the three dividers are bit-per-stage pipelines; they set depth.
// aresetn is synchronous, active low, and clears only valid bits.
// The pipe advances unless its last stage holds an item that the full output
// register cannot take; the input keeps accepting until that point.
module rotation_matrix_to_quaternion_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [rmq_pkg::DW-1:0] s_m00,
    input  logic signed [rmq_pkg::DW-1:0] s_m01,
    input  logic signed [rmq_pkg::DW-1:0] s_m02,
    input  logic signed [rmq_pkg::DW-1:0] s_m10,
    input  logic signed [rmq_pkg::DW-1:0] s_m11,
    input  logic signed [rmq_pkg::DW-1:0] s_m12,
    input  logic signed [rmq_pkg::DW-1:0] s_m20,
    input  logic signed [rmq_pkg::DW-1:0] s_m21,
    input  logic signed [rmq_pkg::DW-1:0] s_m22,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [rmq_pkg::DW-1:0] m_quat_x,
    output logic signed [rmq_pkg::DW-1:0] m_quat_y,
    output logic signed [rmq_pkg::DW-1:0] m_quat_z,
    output logic signed [rmq_pkg::DW-1:0] m_quat_w,
    output logic [1:0]                    m_case_used
);
    import rmq_pkg::*;

    logic              ce;
    logic              out_load;

    // case select stage
    logic              prep_vld;
    logic [RAD_W-1:0]  prep_rad;
    side_t             prep_side;

    // root pipeline
    logic              sq_vld;
    logic [ROOT_W-1:0] sq_root;
    side_t             sq_side;

    // dividers
    logic                 dv_vld0, dv_vld1, dv_vld2;
    logic signed [DW-1:0] dv_q0, dv_q1, dv_q2;

    // dominant component: (r + 1) >> 1, saturated
    logic [ROOT_W:0]      dom_wide;
    logic signed [DW-1:0] dom;

    // case and dominant value ride alongside the dividers
    sel_t                 dl_sel_reg [DIV_LAT];
    logic signed [DW-1:0] dl_dom_reg [DIV_LAT];

    logic                 m_valid_reg;
    logic signed [DW-1:0] qx_reg, qy_reg, qz_reg, qw_reg;
    sel_t                 sel_reg;
    logic signed [DW-1:0] qx_next, qy_next, qz_next, qw_next;

    assign ce       = !dv_vld0 || !m_valid_reg || m_ready;
    assign out_load = dv_vld0 && ce;
    assign s_ready  = ce;

    rmq_prep u_prep (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ce       (ce),
        .in_vld   (s_valid),
        .m00      (s_m00),
        .m01      (s_m01),
        .m02      (s_m02),
        .m10      (s_m10),
        .m11      (s_m11),
        .m12      (s_m12),
        .m20      (s_m20),
        .m21      (s_m21),
        .m22      (s_m22),
        .out_vld  (prep_vld),
        .out_rad  (prep_rad),
        .out_side (prep_side)
    );

    rmq_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ce       (ce),
        .in_vld   (prep_vld),
        .in_rad   (prep_rad),
        .in_side  (prep_side),
        .out_vld  (sq_vld),
        .out_root (sq_root),
        .out_side (sq_side)
    );

    rmq_div u_div0 (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ce      (ce),
        .in_vld  (sq_vld),
        .in_n    (sq_side.n0),
        .in_root (sq_root),
        .out_vld (dv_vld0),
        .out_q   (dv_q0)
    );

    rmq_div u_div1 (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ce      (ce),
        .in_vld  (sq_vld),
        .in_n    (sq_side.n1),
        .in_root (sq_root),
        .out_vld (dv_vld1),
        .out_q   (dv_q1)
    );

    rmq_div u_div2 (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ce      (ce),
        .in_vld  (sq_vld),
        .in_n    (sq_side.n2),
        .in_root (sq_root),
        .out_vld (dv_vld2),
        .out_q   (dv_q2)
    );

    assign dom_wide = ((ROOT_W + 1)'(sq_root) + (ROOT_W + 1)'(1)) >> 1;
    assign dom      = (dom_wide > (ROOT_W + 1)'(QMAX)) ? QMAX : DW'(dom_wide);

    always_ff @(posedge aclk) begin
        if (ce) begin
            dl_sel_reg[0] <= sq_side.sel;
            dl_dom_reg[0] <= dom;
            for (int i = 1; i < DIV_LAT; i++) begin
                dl_sel_reg[i] <= dl_sel_reg[i-1];
                dl_dom_reg[i] <= dl_dom_reg[i-1];
            end
        end
    end

    // place dominant and divided components by case
    always_comb begin
        unique case (dl_sel_reg[DIV_LAT-1])
            SEL_W: begin
                qx_next = dv_q0;
                qy_next = dv_q1;
                qz_next = dv_q2;
                qw_next = dl_dom_reg[DIV_LAT-1];
            end
            SEL_X: begin
                qx_next = dl_dom_reg[DIV_LAT-1];
                qy_next = dv_q0;
                qz_next = dv_q1;
                qw_next = dv_q2;
            end
            SEL_Y: begin
                qx_next = dv_q0;
                qy_next = dl_dom_reg[DIV_LAT-1];
                qz_next = dv_q1;
                qw_next = dv_q2;
            end
            default: begin
                qx_next = dv_q0;
                qy_next = dv_q1;
                qz_next = dl_dom_reg[DIV_LAT-1];
                qw_next = dv_q2;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            qx_reg  <= qx_next;
            qy_reg  <= qy_next;
            qz_reg  <= qz_next;
            qw_reg  <= qw_next;
            sel_reg <= dl_sel_reg[DIV_LAT-1];
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_quat_x    = qx_reg;
    assign m_quat_y    = qy_reg;
    assign m_quat_z    = qz_reg;
    assign m_quat_w    = qw_reg;
    assign m_case_used = sel_reg;

    // input stalls only behind a blocked output
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready && dv_vld0))
        else $error("input stalled without a blocked output");

    // divider lanes stay in lockstep
    a_lanes_lockstep: assert property (@(posedge aclk) disable iff (!aresetn)
        (dv_vld0 == dv_vld1) && (dv_vld0 == dv_vld2))
        else $error("divider lanes out of step");

    // a loaded item shows at the output next cycle
    a_load_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> m_valid)
        else $error("loaded item not presented");

    // a blocked output item is not overwritten
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !out_load)
        else $error("output overwritten while waiting");

endmodule

// ===== dv/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rmq_pkg::*;

    localparam int FB          = 14;
    localparam int LATENCY     = 36;
    localparam int MAX_CYCLE   = 400000;
    localparam int HOLD_CYCLES = 200;

    // expected quaternion for one accepted matrix
    typedef struct {
        logic signed [15:0] qx;
        logic signed [15:0] qy;
        logic signed [15:0] qz;
        logic signed [15:0] qw;
        sel_t               sel;
    } quat_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [15:0] s_m00 = '0, s_m01 = '0, s_m02 = '0;
    logic signed [15:0] s_m10 = '0, s_m11 = '0, s_m12 = '0;
    logic signed [15:0] s_m20 = '0, s_m21 = '0, s_m22 = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [15:0] m_quat_x, m_quat_y, m_quat_z, m_quat_w;
    logic [1:0] m_case_used;

    quat_t quat_fifo[$];
    int    errors = 0;
    int    n_sent = 0;
    int    n_recv = 0;
    int    cycle = 0;
    int    src_idle_pct = 0;   // sender gap chance, percent
    int    snk_idle_pct = 0;   // receiver stall chance, percent
    int    hold_req = 0;       // bumped by a test to start a receiver hold-off
    int    hold_ack = 0;
    int    hold_off = 0;       // cycles of forced receiver stall left
    int    case_hits[4] = '{0, 0, 0, 0};

    always #5 aclk = ~aclk;

    rotation_matrix_to_quaternion_top uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_m00(s_m00), .s_m01(s_m01), .s_m02(s_m02),
        .s_m10(s_m10), .s_m11(s_m11), .s_m12(s_m12),
        .s_m20(s_m20), .s_m21(s_m21), .s_m22(s_m22),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_quat_x(m_quat_x), .m_quat_y(m_quat_y), .m_quat_z(m_quat_z),
        .m_quat_w(m_quat_w), .m_case_used(m_case_used)
    );

    // integer square root, bit by bit
    function automatic longint unsigned isqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic signed [15:0] clamp16(longint v);
        if (v > 32767) return 16'sh7fff;
        if (v < -32768) return 16'sh8000;
        return v[15:0];
    endfunction

    // pair value over 2r, rounded half away from zero
    function automatic logic signed [15:0] pair_over_2r(longint n, longint unsigned r);
        longint unsigned mag, q;
        if (r == 0) return (n > 0) ? 16'sh7fff : ((n < 0) ? 16'sh8000 : 16'sh0);
        mag = (n < 0) ? -n : n;
        q = ((mag << FB) + r) / (r << 1);
        if (q > (64'd1 << 20)) q = 64'd1 << 20;
        return clamp16((n < 0) ? -longint'(q) : longint'(q));
    endfunction

    function automatic quat_t shepperd(logic signed [15:0] m[9]);
        longint a[9];
        longint trace, rad;
        longint unsigned r;
        logic signed [15:0] dom;
        quat_t q;
        for (int i = 0; i < 9; i++) a[i] = m[i];
        trace = a[0] + a[4] + a[8];
        if (trace > 0) begin
            q.sel = SEL_W; rad = (1 << FB) + trace;
        end else if (a[0] > a[4] && a[0] > a[8]) begin
            q.sel = SEL_X; rad = (1 << FB) + a[0] - a[4] - a[8];
        end else if (a[4] > a[8]) begin
            q.sel = SEL_Y; rad = (1 << FB) + a[4] - a[0] - a[8];
        end else begin
            q.sel = SEL_Z; rad = (1 << FB) + a[8] - a[0] - a[4];
        end
        r = (rad > 0) ? isqrt(longint'(rad) << FB) : 0;
        dom = clamp16(longint'((r + 1) >> 1));
        case (q.sel)
            SEL_W: begin
                q.qw = dom;
                q.qx = pair_over_2r(a[7] - a[5], r);
                q.qy = pair_over_2r(a[2] - a[6], r);
                q.qz = pair_over_2r(a[3] - a[1], r);
            end
            SEL_X: begin
                q.qx = dom;
                q.qy = pair_over_2r(a[1] + a[3], r);
                q.qz = pair_over_2r(a[2] + a[6], r);
                q.qw = pair_over_2r(a[7] - a[5], r);
            end
            SEL_Y: begin
                q.qy = dom;
                q.qx = pair_over_2r(a[1] + a[3], r);
                q.qz = pair_over_2r(a[5] + a[7], r);
                q.qw = pair_over_2r(a[2] - a[6], r);
            end
            default: begin
                q.qz = dom;
                q.qx = pair_over_2r(a[2] + a[6], r);
                q.qy = pair_over_2r(a[5] + a[7], r);
                q.qw = pair_over_2r(a[3] - a[1], r);
            end
        endcase
        return q;
    endfunction

    // sends one matrix item; valid stays high across back-to-back items
    task automatic send_matrix(logic signed [15:0] m[9]);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        {s_m00, s_m01, s_m02} <= {m[0], m[1], m[2]};
        {s_m10, s_m11, s_m12} <= {m[3], m[4], m[5]};
        {s_m20, s_m21, s_m22} <= {m[6], m[7], m[8]};
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        quat_fifo.push_back(shepperd(m));
        n_sent++;
    endtask

    task automatic go_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // waits for the pipe to drain completely
    task automatic drain();
        go_idle();
        while (quat_fifo.size() != 0) @(posedge aclk);
    endtask

    function automatic logic signed [15:0] rand_entry();
        int k;
        k = $urandom_range(9);
        if (k == 0) return 16'sh4000;
        if (k == 1) return -16'sh4000;
        if (k == 2) return 16'($urandom);   // any bit pattern
        return 16'($signed($urandom_range(32768)) - 16384);
    endfunction

    // near-rotation: diagonal biased toward one dominant entry, or all positive, or left random
    task automatic rand_matrix(output logic signed [15:0] m[9]);
        int pick;
        for (int i = 0; i < 9; i++) m[i] = rand_entry();
        pick = $urandom_range(5);
        if (pick < 4 && pick > 0) begin
            m[0] = 16'(-$signed($urandom_range(16384)));
            m[4] = 16'(-$signed($urandom_range(16384)));
            m[8] = 16'(-$signed($urandom_range(16384)));
            m[(pick - 1) * 4] = 16'($urandom_range(16384));
            if ($urandom_range(3) == 0) m[(pick % 3) * 4] = m[(pick - 1) * 4];
        end else if (pick == 0) begin
            m[0] = 16'($urandom_range(16384));
            m[4] = 16'($urandom_range(16384));
            m[8] = 16'($urandom_range(16384));
        end
    endtask

    task automatic test_directed();
        logic signed [15:0] m[9];
        logic signed [15:0] ext[4] = '{16'sh4000, -16'sh4000, 16'sh7fff, 16'sh8000};
        m = '{16'sh4000, 0, 0, 0, 16'sh4000, 0, 0, 0, 16'sh4000};   // identity
        send_matrix(m);
        m = '{16'sh4000, 0, 0, 0, -16'sh4000, 0, 0, 0, -16'sh4000}; // x dominant
        send_matrix(m);
        m = '{-16'sh4000, 0, 0, 0, 16'sh4000, 0, 0, 0, -16'sh4000};
        send_matrix(m);
        m = '{-16'sh4000, 0, 0, 0, -16'sh4000, 0, 0, 0, 16'sh4000};
        send_matrix(m);
        // diagonal ties with zero or negative trace
        m = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
        send_matrix(m);
        m = '{-16'sh1000, 0, 0, 0, -16'sh1000, 0, 0, 0, -16'sh2000};
        send_matrix(m);
        m = '{-16'sh2000, 0, 0, 0, -16'sh1000, 0, 0, 0, -16'sh1000};
        send_matrix(m);
        m = '{-16'sh1000, 0, 0, 0, -16'sh2000, 0, 0, 0, -16'sh1000};
        send_matrix(m);
        // trace exactly zero versus one
        m = '{16'sh0001, 0, 0, 0, 16'sh0000, 0, 0, 0, -16'sh0001};
        send_matrix(m);
        m = '{16'sh0001, 0, 0, 0, 16'sh0000, 0, 0, 0, 16'sh0000};
        send_matrix(m);
        // saturating off-diagonals with small root
        for (int k = 0; k < 4; k++) begin
            for (int i = 0; i < 9; i++) m[i] = ext[(i + k) % 4];
            send_matrix(m);
            for (int i = 0; i < 9; i++) m[i] = (i % 4 == 0) ? 16'sh8000 : ext[k];
            send_matrix(m);
        end
        m = '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
              16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff};
        send_matrix(m);
        m = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
              16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000};
        send_matrix(m);
        drain();
    endtask

    task automatic test_random(int count, int src_pct, int snk_pct);
        logic signed [15:0] m[9];
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        for (int i = 0; i < count; i++) begin
            rand_matrix(m);
            send_matrix(m);
        end
        drain();
    endtask

    // receiver holds off while the sender keeps offering, so input stalls
    task automatic test_backpressure();
        logic signed [15:0] m[9];
        src_idle_pct = 0;
        snk_idle_pct = 0;
        hold_req++;
        for (int i = 0; i < 120; i++) begin
            rand_matrix(m);
            send_matrix(m);
        end
        drain();
    endtask

    // receiver side: random stalls, plus forced hold-off counted here
    always @(posedge aclk) begin
        if (hold_req != hold_ack) begin
            hold_ack <= hold_req;
            hold_off <= HOLD_CYCLES - 1;
            m_ready <= 1'b0;
        end else if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // result checker
    always @(posedge aclk) begin
        quat_t q;
        if (aresetn && m_valid && m_ready) begin
            n_recv++;
            if (quat_fifo.size() == 0) begin
                $display("%0t: unexpected result x=%0d", $time, m_quat_x);
                errors++;
            end else begin
                q = quat_fifo.pop_front();
                case_hits[q.sel]++;
                if (m_quat_x !== q.qx || m_quat_y !== q.qy || m_quat_z !== q.qz ||
                    m_quat_w !== q.qw || m_case_used !== q.sel) begin
                    $display("%0t: mismatch expected x=%0d y=%0d z=%0d w=%0d case=%0d",
                             $time, q.qx, q.qy, q.qz, q.qw, q.sel);
                    $display("%0t:          actual   x=%0d y=%0d z=%0d w=%0d case=%0d",
                             $time, m_quat_x, m_quat_y, m_quat_z, m_quat_w, m_case_used);
                    errors++;
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle <= cycle + 1;
        if (cycle > MAX_CYCLE) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random(400, 13, 75);
        test_random(400, 75, 13);
        test_random(400, 0, 0);
        test_backpressure();
        repeat (LATENCY + 4) @(posedge aclk);
        if (quat_fifo.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, quat_fifo.size());
        end
        $display("Sent %0d matrices, checked %0d quaternions under gaps and stalls", n_sent,
                 n_recv);
        $display("Case counts w/x/y/z: %0d %0d %0d %0d", case_hits[0], case_hits[1],
                 case_hits[2], case_hits[3]);
        if (errors == 0 && quat_fifo.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
rtl/rmq_pkg.sv
rtl/rmq_prep.sv
rtl/rmq_sqrt.sv
rtl/rmq_div.sv
rtl/rotation_matrix_to_quaternion_top.sv
dv/tb_top.sv
